// ----- hw/rtl/lrec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lrec_pkg;

	localparam int LOOP_DEPTH_DEF  = 1048576;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int LEN_W   = 21;
	localparam int LEVEL_W = 17;
	localparam int XF_W    = 11;
	localparam int CFG_W   = 21;
	localparam int CIDX_W  = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = 17'd52429;
	localparam logic [LEVEL_W-1:0] ALPHA_RST = 17'd65;
	localparam logic [XF_W-1:0]    XFADE_RST = 11'd240;
	localparam logic [LEN_W-1:0]   MINLEN_RST = 21'd4800;

	localparam logic [CIDX_W-1:0] CFG_ENABLE   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_STEREO   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_LEVEL    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_ALPHA    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_XFADE    = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_MINLEN   = 3'd5;

	typedef enum logic [2:0] {
		MODE_EMPTY = 3'd0,
		MODE_IDLE  = 3'd1,
		MODE_REC   = 3'd2,
		MODE_PLAY  = 3'd3,
		MODE_DUB   = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_REC,
		SEQ_RD,
		SEQ_MA,
		SEQ_MB,
		SEQ_DIV,
		SEQ_GAIN,
		SEQ_C1,
		SEQ_C2,
		SEQ_DONE
	} seq_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lrec_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lrec_in_if import lrec_pkg::*; #(
	parameter int SB = SAMPLE_BITS_DEF
) ();
	logic          valid;
	logic          ready;
	logic          cmd_clear;
	logic          cmd_record;
	logic          cmd_play;
	logic          cmd_overdub;
	logic signed [SB-1:0] in_left;
	logic signed [SB-1:0] in_right;

	modport source (output valid, cmd_clear, cmd_record, cmd_play, cmd_overdub,
		in_left, in_right, input ready);
	modport sink (input valid, cmd_clear, cmd_record, cmd_play, cmd_overdub,
		in_left, in_right, output ready);
endinterface

interface lrec_out_if import lrec_pkg::*; #(
	parameter int SB = SAMPLE_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] out_left;
	logic signed [SB-1:0] out_right;
	logic [2:0]           mode;
	logic                 loop_present;
	logic [LEN_W-1:0]     loop_length_out;
	logic [LEN_W-1:0]     playhead_out;

	modport source (output valid, out_left, out_right, mode, loop_present,
		loop_length_out, playhead_out, input ready);
	modport sink (input valid, out_left, out_right, mode, loop_present,
		loop_length_out, playhead_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/audio_loop_recorder_overdub_core.sv -----
// Stereo loop recorder with overdub.
// sample_in carries one stereo sample plus command bits (clear, record, play,
// overdub, applied in that order); sample_out returns one result per transfer:
// the output pair, the looper mode, loop length and playhead.
// The cfg port writes registers by index (enable, stereo, level, alpha,
// crossfade length, minimum loop length); they are to be written only while
// the block is idle, which the block itself does not enforce.
// One sample is worked at a time. A sample that does not play passes states
// REC, RD and DONE (REC and DONE when disabled); playback adds MA, GAIN, C1
// and C2 per active channel (one channel in mono), a second C1 and C2 per
// channel when overdubbing, and inside the boundary crossfade MB and the
// bit-serial crossfade divider per channel. The loop stores are single
// arrays with one write and two registered reads per cycle; the read-modify-write
// of overdub completes before the next sample is taken.
// A new sample is taken while the previous result still waits in the output
// register; the block stalls at its final step until that register frees.
// Reset empties the looper and restores the register defaults; store
// contents are undefined until recorded.
`timescale 1ns / 1ps
`default_nettype none
module audio_loop_recorder_overdub_core import lrec_pkg::*; #(
	parameter int LOOP_DEPTH  = LOOP_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	lrec_in_if.sink            sample_in,
	lrec_out_if.source         sample_out,
	input  wire                cfg_we,
	input  wire [CIDX_W-1:0]   cfg_index,
	input  wire [CFG_W-1:0]    cfg_data
);

	localparam int B    = SAMPLE_BITS;
	localparam int AW   = $clog2(LOOP_DEPTH);
	localparam int CW   = AW + 1;
	localparam int MW   = (CW > LEN_W) ? CW : LEN_W;
	localparam int ACCW = B + 13;
	localparam int XW   = B + 3;
	localparam int NCW  = $clog2(ACCW);
	localparam logic [CW-1:0]  DEPTH_C = CW'(LOOP_DEPTH);
	localparam logic [B-1:0]   FULL    = {1'b1, {(B-1){1'b0}}};
	localparam logic [NCW-1:0] DIV_LAST = NCW'(ACCW - 1);

	typedef struct packed {
		mode_t         mode;
		logic          v;
		logic [CW-1:0] len;
		logic [CW-1:0] rc;
		logic [AW-1:0] pp;
	} ctl_t;

	function automatic ctl_t clear_fn(ctl_t c);
		ctl_t r;
		r      = c;
		r.v    = 1'b0;
		r.len  = '0;
		r.rc   = '0;
		r.pp   = '0;
		r.mode = MODE_EMPTY;
		return r;
	endfunction

	function automatic ctl_t stop_fn(ctl_t c, logic [LEN_W-1:0] min_len);
		ctl_t r;
		logic [CW-1:0] l;
		r = c;
		l = (c.rc > DEPTH_C) ? DEPTH_C : c.rc;
		if (MW'(l) < MW'(min_len)) begin
			r = clear_fn(c);
		end else begin
			r.len  = l;
			r.v    = 1'b1;
			r.pp   = '0;
			r.mode = MODE_PLAY;
		end
		return r;
	endfunction

	// registers
	logic                enable_q, stereo_q;
	logic [LEVEL_W-1:0]  level_q, alpha_q, s_q;
	logic [XF_W-1:0]     xfade_q;
	logic [LEN_W-1:0]    minlen_q;
	ctl_t                ctl_q, cmd_c;
	seq_t                seq_q, seq_d;
	logic                ch_q, dub_q, ov_q;

	logic signed [B-1:0] left_mem  [LOOP_DEPTH];
	logic signed [B-1:0] right_mem [LOOP_DEPTH];
	logic signed [B-1:0] rd_lp_q, rd_ls_q, rd_rp_q, rd_rs_q;

	logic signed [B-1:0] inl_q, inr_q, res_l_q, res_r_q;
	logic [AW-1:0]       pos_q;
	logic [XF_W-1:0]     xf_q, t_q;
	logic                cross_q;
	logic signed [ACCW-1:0] acc_q;
	logic [ACCW-1:0]     num_q;
	logic [XF_W-1:0]     rem_q;
	logic [NCW-1:0]      cnt_q;
	logic                neg_q;
	logic signed [XW-1:0] x_q;
	logic [B-1:0]        a_q, a2_q;
	logic                cneg_q;

	logic signed [B-1:0] out_l_q, out_r_q;
	mode_t               out_mode_q;
	logic                out_lp_q;
	logic [LEN_W-1:0]    out_len_q, out_ph_q;

	logic accept, load;
	assign accept = sample_in.valid && sample_in.ready;
	assign sample_in.ready = (seq_q == SEQ_IDLE);
	assign load = (seq_q == SEQ_DONE) && (!ov_q || sample_out.ready);

	// commands
	always_comb begin
		ctl_t c;
		c = ctl_q;
		if (sample_in.cmd_clear) c = clear_fn(c);
		if (sample_in.cmd_record) begin
			if (c.mode == MODE_REC) begin
				c = stop_fn(c, minlen_q);
			end else begin
				c.v    = 1'b0;
				c.len  = '0;
				c.rc   = '0;
				c.pp   = '0;
				c.mode = MODE_REC;
			end
		end
		if (sample_in.cmd_play) begin
			if (c.mode == MODE_REC) begin
				c = stop_fn(c, minlen_q);
			end else if (c.v) begin
				if (c.mode == MODE_PLAY || c.mode == MODE_DUB) c.mode = MODE_IDLE;
				else if (c.mode == MODE_IDLE || c.mode == MODE_EMPTY) c.mode = MODE_PLAY;
			end
		end
		if (sample_in.cmd_overdub && c.mode != MODE_REC && c.v) begin
			if (c.mode == MODE_DUB) c.mode = MODE_PLAY;
			else if (c.mode == MODE_PLAY || c.mode == MODE_IDLE) c.mode = MODE_DUB;
		end
		cmd_c = c;
	end

	// level smoothing
	logic [LEVEL_W-1:0] tgt, alf, sdiff, sinc, s_next;
	logic               sup;
	logic [2*LEVEL_W:0] sprod;
	always_comb begin
		tgt    = (level_q > LEVEL_ONE) ? LEVEL_ONE : level_q;
		alf    = (alpha_q > LEVEL_ONE) ? LEVEL_ONE : alpha_q;
		sup    = (tgt >= s_q);
		sdiff  = sup ? (tgt - s_q) : (s_q - tgt);
		sprod  = (2*LEVEL_W+1)'(alf) * (2*LEVEL_W+1)'(sdiff) + (2*LEVEL_W+1)'(32768);
		sinc   = LEVEL_W'(sprod >> 16);
		s_next = sup ? (s_q + sinc) : (s_q - sinc);
	end

	// playback addressing
	logic          play_go, rec_go, rec_full, cross_c;
	logic [AW-1:0] pos_c, pp_next;
	logic [CW-1:0] half, xstart, pos_inc;
	logic [XF_W-1:0] xf_c, t_c;
	always_comb begin
		play_go = ctl_q.v && (ctl_q.len != '0) &&
			(ctl_q.mode == MODE_PLAY || ctl_q.mode == MODE_DUB);
		rec_go   = enable_q && (ctl_q.mode == MODE_REC);
		rec_full = (ctl_q.rc >= DEPTH_C);
		pos_c    = (CW'(ctl_q.pp) < ctl_q.len) ? ctl_q.pp : '0;
		half     = ctl_q.len >> 1;
		xf_c     = (CW'(xfade_q) < half) ? xfade_q : XF_W'(half);
		xstart   = ctl_q.len - CW'(xf_c);
		cross_c  = (xf_c != '0) && (CW'(pos_c) >= xstart);
		t_c      = XF_W'(CW'(pos_c) - xstart);
		pos_inc  = CW'(pos_c) + CW'(1);
		pp_next  = (pos_inc >= ctl_q.len) ? '0 : AW'(pos_inc);
	end

	// datapath selects
	logic signed [B-1:0]    dpos, dsp, in_ch;
	logic signed [ACCW-1:0] mprod, msum;
	logic [XF_W:0]          rs;
	logic                   rge;
	logic [B-1:0]           quo;
	logic signed [B:0]      loopv;
	logic signed [B+18:0]   gprod, gq;
	logic [XW-1:0]          ax;
	logic [B-1:0]           a_c, a3, yu, clip_y;
	logic [2*B-1:0]         pa, pb;
	logic [B+1:0]           y3;
	always_comb begin
		dpos  = ch_q ? rd_rp_q : rd_lp_q;
		dsp   = ch_q ? rd_rs_q : rd_ls_q;
		in_ch = ch_q ? inr_q : inl_q;
		mprod = ACCW'(dpos * $signed({1'b0, xf_q - t_q}));
		msum  = acc_q + ACCW'(dsp * $signed({1'b0, t_q}));
		rs    = {rem_q, num_q[ACCW-1]};
		rge   = (rs >= {1'b0, xf_q});
		quo   = num_q[B-1:0];
		if (cross_q) loopv = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		else         loopv = (B+1)'(dpos);
		gprod = (B+19)'(loopv * $signed({1'b0, s_q}));
		gq    = (gprod < 0) ? ((gprod + (B+19)'(65535)) >>> 16) : (gprod >>> 16);
		ax    = x_q[XW-1] ? $unsigned(-x_q) : $unsigned(x_q);
		a_c   = (ax > XW'(FULL)) ? FULL : ax[B-1:0];
		pa    = (2*B)'(a_c) * (2*B)'(a_c);
		pb    = (2*B)'(a2_q) * (2*B)'(a_q);
		a3    = B'(pb >> (B-1));
		y3    = (B+2)'(a_q) * (B+2)'(3) - (B+2)'(a3);
		yu    = B'(y3 >> 1);
		if (cneg_q)              clip_y = B'(~yu + B'(1));
		else if (yu > FULL - 1)  clip_y = FULL - B'(1);
		else                     clip_y = yu;
	end

	// store access
	logic                wr_l, wr_r;
	logic [AW-1:0]       wr_addr;
	logic signed [B-1:0] wr_dl, wr_dr;
	always_comb begin
		wr_l    = 1'b0;
		wr_r    = 1'b0;
		wr_addr = pos_q;
		wr_dl   = clip_y;
		wr_dr   = clip_y;
		if (seq_q == SEQ_REC && rec_go && !rec_full) begin
			wr_l    = 1'b1;
			wr_r    = stereo_q;
			wr_addr = AW'(ctl_q.rc);
			wr_dl   = inl_q;
			wr_dr   = inr_q;
		end else if (seq_q == SEQ_C2 && dub_q) begin
			wr_l = !ch_q;
			wr_r = ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_l) left_mem[wr_addr] <= wr_dl;
		if (seq_q == SEQ_RD) begin
			rd_lp_q <= left_mem[pos_c];
			rd_ls_q <= left_mem[AW'(t_c)];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_r) right_mem[wr_addr] <= wr_dr;
		if (seq_q == SEQ_RD) begin
			rd_rp_q <= right_mem[pos_c];
			rd_rs_q <= right_mem[AW'(t_c)];
		end
	end

	// sequencer
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_IDLE: if (accept) seq_d = SEQ_REC;
			SEQ_REC:  seq_d = enable_q ? SEQ_RD : SEQ_DONE;
			SEQ_RD:   seq_d = play_go ? SEQ_MA : SEQ_DONE;
			SEQ_MA:   seq_d = cross_q ? SEQ_MB : SEQ_GAIN;
			SEQ_MB:   seq_d = SEQ_DIV;
			SEQ_DIV:  if (cnt_q == DIV_LAST) seq_d = SEQ_GAIN;
			SEQ_GAIN: seq_d = SEQ_C1;
			SEQ_C1:   seq_d = SEQ_C2;
			SEQ_C2: begin
				priority if (!dub_q && ctl_q.mode == MODE_DUB) seq_d = SEQ_C1;
				else if (!ch_q && stereo_q)                     seq_d = SEQ_MA;
				else                                            seq_d = SEQ_DONE;
			end
			SEQ_DONE: if (load) seq_d = SEQ_IDLE;
			default:  seq_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			stereo_q    <= 1'b1;
			level_q     <= LEVEL_RST;
			alpha_q     <= ALPHA_RST;
			xfade_q     <= XFADE_RST;
			minlen_q    <= MINLEN_RST;
			ctl_q.mode  <= MODE_EMPTY;
			ctl_q.v     <= 1'b0;
			ctl_q.len   <= '0;
			ctl_q.rc    <= '0;
			ctl_q.pp    <= '0;
			s_q         <= LEVEL_RST;
			ch_q        <= 1'b0;
			dub_q       <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_STEREO: stereo_q <= cfg_data[0];
					CFG_LEVEL:  level_q  <= cfg_data[LEVEL_W-1:0];
					CFG_ALPHA:  alpha_q  <= cfg_data[LEVEL_W-1:0];
					CFG_XFADE:  xfade_q  <= cfg_data[XF_W-1:0];
					CFG_MINLEN: minlen_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			unique case (seq_q)
				SEQ_IDLE: if (accept) ctl_q <= cmd_c;
				SEQ_REC: begin
					if (rec_go) begin
						if (rec_full) ctl_q <= stop_fn(ctl_q, minlen_q);
						else          ctl_q.rc <= ctl_q.rc + CW'(1);
					end
					if (enable_q) s_q <= s_next;
				end
				SEQ_RD: begin
					ch_q  <= 1'b0;
					dub_q <= 1'b0;
					if (play_go) ctl_q.pp <= pp_next;
				end
				SEQ_C2: begin
					if (!dub_q && ctl_q.mode == MODE_DUB) begin
						dub_q <= 1'b1;
					end else begin
						dub_q <= 1'b0;
						if (!ch_q && stereo_q) ch_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (load)                          ov_q <= 1'b1;
			else if (ov_q && sample_out.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (seq_q)
			SEQ_IDLE: begin
				if (accept) begin
					inl_q   <= sample_in.in_left;
					inr_q   <= stereo_q ? sample_in.in_right : sample_in.in_left;
					res_l_q <= sample_in.in_left;
					res_r_q <= stereo_q ? sample_in.in_right : sample_in.in_left;
				end
			end
			SEQ_RD: begin
				pos_q   <= pos_c;
				xf_q    <= xf_c;
				t_q     <= t_c;
				cross_q <= cross_c;
			end
			SEQ_MA: acc_q <= mprod;
			SEQ_MB: begin
				neg_q <= (msum < 0);
				num_q <= (msum < 0) ? $unsigned(-msum) : $unsigned(msum);
				rem_q <= '0;
				cnt_q <= '0;
			end
			SEQ_DIV: begin
				rem_q <= rge ? XF_W'(rs - {1'b0, xf_q}) : XF_W'(rs);
				num_q <= {num_q[ACCW-2:0], rge};
				cnt_q <= cnt_q + NCW'(1);
			end
			SEQ_GAIN: x_q <= XW'(in_ch) + XW'(gq);
			SEQ_C1: begin
				cneg_q <= x_q[XW-1];
				a_q    <= a_c;
				a2_q   <= B'(pa >> (B-1));
			end
			SEQ_C2: begin
				if (!dub_q) begin
					if (ch_q) res_r_q <= clip_y;
					else      res_l_q <= clip_y;
					x_q <= XW'(dpos) + XW'(in_ch);
				end
			end
			SEQ_DONE: begin
				if (load) begin
					out_l_q    <= res_l_q;
					out_r_q    <= stereo_q ? res_r_q : res_l_q;
					out_mode_q <= ctl_q.mode;
					out_lp_q   <= ctl_q.v;
					out_len_q  <= LEN_W'(ctl_q.len);
					out_ph_q   <= (ctl_q.mode == MODE_REC) ? LEN_W'(ctl_q.rc)
						: LEN_W'(ctl_q.pp);
				end
			end
			default: ;
		endcase
	end

	assign sample_out.valid           = ov_q;
	assign sample_out.out_left        = out_l_q;
	assign sample_out.out_right       = out_r_q;
	assign sample_out.mode            = out_mode_q;
	assign sample_out.loop_present    = out_lp_q;
	assign sample_out.loop_length_out = out_len_q;
	assign sample_out.playhead_out    = out_ph_q;

	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.rc <= DEPTH_C)
		else $error("record count beyond store depth");

	a_valid_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.v == (ctl_q.mode == MODE_IDLE || ctl_q.mode == MODE_PLAY ||
			ctl_q.mode == MODE_DUB))
		else $error("loop valid flag disagrees with mode");

	a_pp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.v && ctl_q.len != '0) |-> (CW'(ctl_q.pp) < ctl_q.len))
		else $error("playhead outside loop");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (seq_q != SEQ_IDLE))
		else $error("transfer taken without starting work");

endmodule
`default_nettype wire
